// ===== rtl/gpib_ah_pkg.sv =====
// Shared types and constants for the GPIB acceptor handshake core.
package gpib_ah_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam int unsigned RegAddrWidth   = 4;
    localparam logic [1:0]  REG_TERMINATOR = 2'd0;
    localparam logic [1:0]  REG_MAX_COUNT  = 2'd1;
    localparam logic [1:0]  REG_TIMEOUT    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  TerminatorReset = 8'd0;
    localparam logic [7:0]  MaxCountReset   = 8'd255;
    localparam logic [15:0] TimeoutReset    = 16'd40000;

    // Transfer outcome codes
    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_VALID_TIMEOUT   = 2'd1,
        ST_FULL            = 2'd2,
        ST_RELEASE_TIMEOUT = 2'd3
    } status_t;

    // Handshake phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE         = 3'b001,
        PH_WAIT_VALID   = 3'b010,
        PH_WAIT_RELEASE = 3'b100
    } phase_t;

    // Input word operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

endpackage

// ===== rtl/gpib_acceptor_handshake_core.sv =====
// GPIB acceptor (listener) three-wire handshake core, top level.
//
// Input channel (s_*): one word per bus sample. operation = start arms a
// new read transfer; operation = tick presents the sampled DAV, EOI and
// data lines (all active low) for one handshake step.
// Result channel (m_*): exactly one word per input word, giving the NRFD
// and NDAC levels to drive, any byte latched on that tick, the running
// byte count, the end-of-transfer flag and the transfer status.
// Configuration: APB-style port; terminator at 0x0, max count at 0x4,
// DAV wait timeout in ticks at 0x8. Write only while the core is idle.
// A result passes through the input register, then the result register.
// Throughput: one word per cycle while the receiver does not stall;
// the handshake state advances in the single logic pass between the two
// registers.
// Reset (aresetn low, synchronous): phase idle, counters and status
// cleared, registers back to their defaults, both channels empty.
// When the receiver stalls, the result register holds; the input register
// still takes a word if it is empty, and s_ready stays low while it is full.
module gpib_acceptor_handshake_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic                                  s_dav_line,
    input  logic                                  s_eoi_line,
    input  logic [7:0]                            s_data_lines,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_lines_driven,
    output logic                                  m_nrfd_level,
    output logic                                  m_ndac_level,
    output logic                                  m_byte_valid,
    output logic [7:0]                            m_byte_value,
    output logic [7:0]                            m_byte_count,
    output logic                                  m_finished,
    output logic [1:0]                            m_status,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gpib_ah_pkg::RegAddrWidth-1:0]  paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    // Configuration registers
    logic [7:0]  terminator_reg;
    logic [7:0]  max_count_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  reg_index;
    logic        cfg_write;

    // Input register
    logic        in_valid_reg;
    logic        in_op_reg;
    logic        in_dav_reg;
    logic        in_eoi_reg;
    logic [7:0]  in_data_reg;

    // Handshake state
    gpib_ah_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]          timer_reg, timer_next;
    logic [7:0]           count_reg, count_next;
    gpib_ah_pkg::status_t status_reg, status_next;

    // Result register
    logic        out_valid_reg;
    logic        out_driven_reg, out_nrfd_reg, out_ndac_reg;
    logic        out_bvalid_reg, out_fin_reg;
    logic [7:0]  out_bvalue_reg;

    logic        advance;
    logic        byte_valid_next, fin_next;
    logic [7:0]  byte_value_next;
    logic [7:0]  rx_byte;
    logic [7:0]  count_inc;
    logic [15:0] timer_inc;
    logic        timed_out;
    logic        term_hit;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            terminator_reg <= gpib_ah_pkg::TerminatorReset;
            max_count_reg  <= gpib_ah_pkg::MaxCountReset;
            timeout_reg    <= gpib_ah_pkg::TimeoutReset;
        end else if (cfg_write) begin
            unique case (reg_index)
                gpib_ah_pkg::REG_TERMINATOR: terminator_reg <= pwdata[7:0];
                gpib_ah_pkg::REG_MAX_COUNT:  max_count_reg  <= pwdata[7:0];
                gpib_ah_pkg::REG_TIMEOUT:    timeout_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read
    always_comb begin
        unique case (reg_index)
            gpib_ah_pkg::REG_TERMINATOR: prdata = {24'd0, terminator_reg};
            gpib_ah_pkg::REG_MAX_COUNT:  prdata = {24'd0, max_count_reg};
            gpib_ah_pkg::REG_TIMEOUT:    prdata = {16'd0, timeout_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Flow control: the logic pass runs when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_dav_reg  <= s_dav_line;
            in_eoi_reg  <= s_eoi_line;
            in_data_reg <= s_data_lines;
        end
    end

    // Handshake step
    assign rx_byte   = ~in_data_reg;
    assign count_inc = count_reg + 8'd1;
    assign timer_inc = timer_reg + 16'd1;
    assign timed_out = (timer_inc >= timeout_reg);
    assign term_hit  = (terminator_reg == 8'd0) ? !in_eoi_reg
                                                : (rx_byte == terminator_reg);

    always_comb begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        byte_valid_next = 1'b0;
        byte_value_next = 8'd0;
        fin_next        = 1'b0;
        if (in_op_reg == gpib_ah_pkg::OP_START) begin
            phase_next  = gpib_ah_pkg::PH_WAIT_VALID;
            timer_next  = 16'd0;
            count_next  = 8'd0;
            status_next = gpib_ah_pkg::ST_OK;
        end else begin
            unique case (phase_reg)
                gpib_ah_pkg::PH_WAIT_VALID: begin
                    if (!in_dav_reg) begin
                        byte_valid_next = 1'b1;
                        byte_value_next = rx_byte;
                        count_next      = count_inc;
                        timer_next      = 16'd0;
                        if (count_inc == max_count_reg) begin
                            phase_next  = gpib_ah_pkg::PH_IDLE;
                            status_next = gpib_ah_pkg::ST_FULL;
                            fin_next    = 1'b1;
                        end else if (term_hit) begin
                            phase_next  = gpib_ah_pkg::PH_IDLE;
                            status_next = gpib_ah_pkg::ST_OK;
                            fin_next    = 1'b1;
                        end else begin
                            phase_next = gpib_ah_pkg::PH_WAIT_RELEASE;
                        end
                    end else if (timed_out) begin
                        phase_next  = gpib_ah_pkg::PH_IDLE;
                        timer_next  = 16'd0;
                        status_next = gpib_ah_pkg::ST_VALID_TIMEOUT;
                        fin_next    = 1'b1;
                    end else begin
                        timer_next = timer_inc;
                    end
                end
                gpib_ah_pkg::PH_WAIT_RELEASE: begin
                    if (in_dav_reg) begin
                        phase_next = gpib_ah_pkg::PH_WAIT_VALID;
                        timer_next = 16'd0;
                    end else if (timed_out) begin
                        phase_next  = gpib_ah_pkg::PH_IDLE;
                        timer_next  = 16'd0;
                        status_next = gpib_ah_pkg::ST_RELEASE_TIMEOUT;
                        fin_next    = 1'b1;
                    end else begin
                        timer_next = timer_inc;
                    end
                end
                default: begin
                    // ticks while idle change nothing
                    phase_next = gpib_ah_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= gpib_ah_pkg::PH_IDLE;
            timer_reg  <= 16'd0;
            count_reg  <= 8'd0;
            status_reg <= gpib_ah_pkg::ST_OK;
        end else if (advance) begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_driven_reg <= (phase_next != gpib_ah_pkg::PH_IDLE);
            out_nrfd_reg   <= (phase_next != gpib_ah_pkg::PH_WAIT_RELEASE);
            out_ndac_reg   <= (phase_next != gpib_ah_pkg::PH_WAIT_VALID);
            out_bvalid_reg <= byte_valid_next;
            out_bvalue_reg <= byte_value_next;
            out_fin_reg    <= fin_next;
        end
    end

    // Count and status are the state itself once the word is registered
    assign m_valid        = out_valid_reg;
    assign m_lines_driven = out_driven_reg;
    assign m_nrfd_level   = out_nrfd_reg;
    assign m_ndac_level   = out_ndac_reg;
    assign m_byte_valid   = out_bvalid_reg;
    assign m_byte_value   = out_bvalue_reg;
    assign m_finished     = out_fin_reg;

    logic [7:0] out_count_reg;
    logic [1:0] out_status_reg;
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_count_reg  <= count_next;
            out_status_reg <= status_next;
        end
    end
    assign m_byte_count = out_count_reg;
    assign m_status     = out_status_reg;

    // Checks
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == gpib_ah_pkg::PH_IDLE) |-> (timer_reg == 16'd0))
        else $error("wait timer running while idle");

    a_status_when_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != gpib_ah_pkg::ST_OK) |-> !m_lines_driven)
        else $error("error status reported during an active transfer");

    a_byte_not_last_drops_nrfd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_valid && !m_finished) |-> (m_lines_driven && !m_nrfd_level))
        else $error("byte latched without holding off the talker");

    a_finish_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> (!m_lines_driven && m_nrfd_level && m_ndac_level))
        else $error("lines still driven at end of transfer");

endmodule

// ===== test/tb_gpib_acceptor_handshake_core.sv =====
// Self-checking testbench for the GPIB acceptor handshake core.
module tb_gpib_acceptor_handshake_core;

    localparam int WatchdogLimit = 4000;
    localparam int SettleCycles  = 4;
    localparam int TailCycles    = 8;
    localparam int IdlePercent   = 37;
    localparam int MaxReports    = 10;
    localparam int PhaseWords    = 90;

    // One result word as the core presents it
    typedef struct packed {
        logic                 lines_driven;
        logic                 nrfd_level;
        logic                 ndac_level;
        logic                 byte_valid;
        logic [7:0]           byte_value;
        logic [7:0]           byte_count;
        logic                 finished;
        gpib_ah_pkg::status_t status;
    } listen_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic        s_dav_line;
    logic        s_eoi_line;
    logic [7:0]  s_data_lines;
    logic        m_valid;
    logic        m_ready;
    logic        m_lines_driven;
    logic        m_nrfd_level;
    logic        m_ndac_level;
    logic        m_byte_valid;
    logic [7:0]  m_byte_value;
    logic [7:0]  m_byte_count;
    logic        m_finished;
    logic [1:0]  m_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [gpib_ah_pkg::RegAddrWidth-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Listener model: configuration copy and handshake state
    logic [7:0]           cfg_term;
    logic [7:0]           cfg_max;
    logic [15:0]          cfg_timeout;
    gpib_ah_pkg::phase_t  lp_phase;
    logic [15:0]          lp_timer;
    logic [7:0]           lp_count;
    gpib_ah_pkg::status_t lp_status;

    listen_word_t due_words[$];
    listen_word_t seen_word;
    listen_word_t due_word;

    // bookkeeping
    logic steady;
    int   fault_count;
    int   stall_cycles;
    int   words_in;
    int   results_out;
    int   bytes_latched;
    int   endings[4];

    gpib_acceptor_handshake_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_dav_line     (s_dav_line),
        .s_eoi_line     (s_eoi_line),
        .s_data_lines   (s_data_lines),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lines_driven (m_lines_driven),
        .m_nrfd_level   (m_nrfd_level),
        .m_ndac_level   (m_ndac_level),
        .m_byte_valid   (m_byte_valid),
        .m_byte_value   (m_byte_value),
        .m_byte_count   (m_byte_count),
        .m_finished     (m_finished),
        .m_status       (m_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // End the current transfer with the given outcome
    function automatic void close_transfer(input gpib_ah_pkg::status_t outcome);
        lp_status = outcome;
        lp_phase  = gpib_ah_pkg::PH_IDLE;
        lp_timer  = '0;
    endfunction

    // Advance the listener by one word and return the result it should give
    function automatic listen_word_t advance_listener(input logic op, input logic dav,
                                                      input logic eoi, input logic [7:0] data);
        listen_word_t w;
        logic         at_end;
        w = '0;
        if (op == gpib_ah_pkg::OP_START) begin
            lp_phase  = gpib_ah_pkg::PH_WAIT_VALID;
            lp_timer  = '0;
            lp_count  = '0;
            lp_status = gpib_ah_pkg::ST_OK;
        end else if (lp_phase == gpib_ah_pkg::PH_WAIT_VALID) begin
            if (!dav) begin
                w.byte_valid = 1'b1;
                w.byte_value = ~data;
                lp_count     = lp_count + 8'd1;
                // terminator of zero means end on EOI
                at_end = (cfg_term == 8'h00) ? !eoi : (w.byte_value == cfg_term);
                if (lp_count == cfg_max) begin
                    close_transfer(gpib_ah_pkg::ST_FULL);
                    w.finished = 1'b1;
                end else if (at_end) begin
                    close_transfer(gpib_ah_pkg::ST_OK);
                    w.finished = 1'b1;
                end else begin
                    lp_phase = gpib_ah_pkg::PH_WAIT_RELEASE;
                    lp_timer = '0;
                end
            end else begin
                lp_timer = lp_timer + 16'd1;
                if (lp_timer >= cfg_timeout) begin
                    close_transfer(gpib_ah_pkg::ST_VALID_TIMEOUT);
                    w.finished = 1'b1;
                end
            end
        end else if (lp_phase == gpib_ah_pkg::PH_WAIT_RELEASE) begin
            if (dav) begin
                lp_phase = gpib_ah_pkg::PH_WAIT_VALID;
                lp_timer = '0;
            end else begin
                lp_timer = lp_timer + 16'd1;
                if (lp_timer >= cfg_timeout) begin
                    close_transfer(gpib_ah_pkg::ST_RELEASE_TIMEOUT);
                    w.finished = 1'b1;
                end
            end
        end
        // released lines read as pulled high
        w.lines_driven = (lp_phase != gpib_ah_pkg::PH_IDLE);
        w.nrfd_level   = (lp_phase != gpib_ah_pkg::PH_WAIT_RELEASE);
        w.ndac_level   = (lp_phase != gpib_ah_pkg::PH_WAIT_VALID);
        w.byte_count   = lp_count;
        w.status       = lp_status;
        return w;
    endfunction

    function automatic string describe_word(input listen_word_t w);
        return $sformatf("drv=%b nrfd=%b ndac=%b bv=%b byte=%02h cnt=%0d fin=%b st=%0d",
                         w.lines_driven, w.nrfd_level, w.ndac_level, w.byte_valid,
                         w.byte_value, w.byte_count, w.finished, w.status);
    endfunction

    task automatic note_fault(input string msg);
        if (fault_count < MaxReports) begin
            $display("[%0t] %s", $realtime, msg);
        end
        fault_count++;
    endtask

    // Present one word, wait for acceptance and log the expected result
    task automatic send_word(input logic op, input logic dav, input logic eoi,
                             input logic [7:0] data);
        listen_word_t w;
        while (!steady && $urandom_range(99) < IdlePercent) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_operation  = op;
        s_dav_line   = dav;
        s_eoi_line   = eoi;
        s_data_lines = data;
        do @(posedge aclk); while (!s_ready);
        w = advance_listener(op, dav, eoi, data);
        due_words.push_back(w);
        words_in++;
        if (w.byte_valid) bytes_latched++;
        if (w.finished) endings[int'(w.status)]++;
        @(negedge aclk);
    endtask

    task automatic tick(input logic dav, input logic eoi, input logic [7:0] data);
        send_word(gpib_ah_pkg::OP_TICK, dav, eoi, data);
    endtask

    task automatic start_transfer();
        send_word(gpib_ah_pkg::OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
    endtask

    // Stop sending and let every outstanding result drain
    task automatic settle();
        s_valid = 1'b0;
        while (due_words.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    // Register write then read back, setup and access cycles each
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] got;
        logic [31:0] mask;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        mask = (idx == gpib_ah_pkg::REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
        case (idx)
            gpib_ah_pkg::REG_TERMINATOR: cfg_term    = value[7:0];
            gpib_ah_pkg::REG_MAX_COUNT:  cfg_max     = value[7:0];
            gpib_ah_pkg::REG_TIMEOUT:    cfg_timeout = value[15:0];
            default: ;
        endcase
        if ((got & mask) !== (value & mask)) begin
            note_fault($sformatf("register %0d read back: expected %0h, got %0h",
                                 idx, value & mask, got & mask));
        end
    endtask

    task automatic apply_settings(input logic [7:0] term, input logic [7:0] limit,
                                  input logic [15:0] ticks);
        settle();
        write_reg(gpib_ah_pkg::REG_TERMINATOR, {24'd0, term});
        write_reg(gpib_ah_pkg::REG_MAX_COUNT, {24'd0, limit});
        write_reg(gpib_ah_pkg::REG_TIMEOUT, {16'd0, ticks});
    endtask

    // Reset defaults: idle tick ignored, EOI ends the transfer
    task automatic test_eoi_transfer();
        tick(1'b0, 1'b0, 8'h55);
        start_transfer();
        tick(1'b1, 1'b1, 8'hA0);
        tick(1'b0, 1'b1, 8'h00);
        tick(1'b0, 1'b1, 8'h00);
        tick(1'b1, 1'b1, 8'h3C);
        tick(1'b0, 1'b0, 8'hFF);
        tick(1'b1, 1'b0, 8'hFF);
    endtask

    // Terminator match, buffer full, and both on one byte
    task automatic test_terminator_and_full();
        apply_settings(8'h1A, 8'd4, 16'd3);
        start_transfer();
        tick(1'b0, 1'b0, 8'h41);
        tick(1'b1, 1'b1, 8'h00);
        tick(1'b0, 1'b1, 8'hE5);
        start_transfer();
        repeat (4) begin
            tick(1'b0, 1'b1, 8'h0F);
            tick(1'b1, 1'b1, 8'hF0);
        end
        apply_settings(8'hFF, 8'd2, 16'd3);
        start_transfer();
        tick(1'b0, 1'b1, 8'h55);
        tick(1'b1, 1'b1, 8'h55);
        tick(1'b0, 1'b1, 8'h00);
    endtask

    // Both DAV timeouts, restart mid-transfer, zero timeout
    task automatic test_timeouts_and_restart();
        apply_settings(8'h2B, 8'd255, 16'd3);
        start_transfer();
        repeat (3) tick(1'b1, 1'b1, 8'h81);
        start_transfer();
        tick(1'b0, 1'b1, 8'h00);
        repeat (3) tick(1'b0, 1'b0, 8'h7E);
        start_transfer();
        tick(1'b0, 1'b1, 8'h10);
        start_transfer();
        tick(1'b0, 1'b1, 8'hD4);
        apply_settings(8'h40, 8'd255, 16'd0);
        start_transfer();
        tick(1'b1, 1'b1, 8'h00);
        start_transfer();
        tick(1'b0, 1'b1, 8'h00);
        tick(1'b0, 1'b1, 8'h00);
    endtask

    // One long transfer that runs until the count limit
    task automatic fill_buffer(input logic [7:0] limit);
        apply_settings(8'h00, limit, 16'hFFFF);
        start_transfer();
        repeat ((limit == 8'd0) ? 256 : int'(limit)) begin
            tick(1'b0, 1'b1, 8'($urandom_range(255)));
            tick(1'b1, 1'b1, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_count_limits();
        steady = 1'b1;
        fill_buffer(8'd255);
        steady = 1'b0;
        fill_buffer(8'd0);
    endtask

    // Talker-like random traffic steered by the listener phase, some noise
    task automatic test_random_traffic();
        int         used;
        logic       op;
        logic       dav;
        logic       eoi;
        logic [7:0] data;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: apply_settings(8'h00, 8'd255, 16'hFFFF);
                1: apply_settings(8'h2B, 8'd1, 16'd1);
                2: apply_settings(8'hFF, 8'd6, 16'd3);
                3: apply_settings(8'h00, 8'd3, 16'd2);
                4: apply_settings(8'($urandom_range(255)), 8'($urandom_range(1, 255)),
                                  16'($urandom_range(1, 8)));
                5: apply_settings(8'h40, 8'd0, 16'd5);
                default: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                        16'($urandom_range(4)));
            endcase
            steady = (p == 2);
            used   = 0;
            while (used < PhaseWords) begin
                op   = gpib_ah_pkg::OP_TICK;
                dav  = 1'($urandom_range(1));
                eoi  = 1'($urandom_range(1));
                data = 8'($urandom_range(255));
                if ($urandom_range(99) >= 6) begin
                    case (lp_phase)
                        gpib_ah_pkg::PH_IDLE: op = gpib_ah_pkg::OP_START;
                        gpib_ah_pkg::PH_WAIT_VALID: begin
                            dav = ($urandom_range(99) < 30);
                            eoi = ($urandom_range(99) >= 15);
                            if (cfg_term != 8'h00 && $urandom_range(99) < 20) data = ~cfg_term;
                        end
                        gpib_ah_pkg::PH_WAIT_RELEASE: dav = ($urandom_range(99) >= 30);
                        default: ;
                    endcase
                end else begin
                    op = 1'($urandom_range(1));
                end
                if (op == gpib_ah_pkg::OP_START || lp_phase != gpib_ah_pkg::PH_IDLE) used++;
                send_word(op, dav, eoi, data);
            end
        end
        steady = 1'b0;
    endtask

    // Receiver stalls at random outside the steady stretches
    always @(negedge aclk) begin
        m_ready = steady || ($urandom_range(99) >= IdlePercent);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_out++;
            seen_word = {m_lines_driven, m_nrfd_level, m_ndac_level, m_byte_valid,
                         m_byte_value, m_byte_count, m_finished, m_status};
            if (due_words.size() == 0) begin
                note_fault($sformatf("result with nothing outstanding: %s",
                                     describe_word(seen_word)));
            end else begin
                due_word = due_words.pop_front();
                if (seen_word !== due_word) begin
                    note_fault($sformatf("mismatch: expected %s, got %s",
                                         describe_word(due_word), describe_word(seen_word)));
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WatchdogLimit) begin
                $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                         stall_cycles, due_words.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = gpib_ah_pkg::OP_TICK;
        s_dav_line   = 1'b1;
        s_eoi_line   = 1'b1;
        s_data_lines = 8'h00;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = 32'd0;
        steady       = 1'b0;
        fault_count  = 0;
        stall_cycles = 0;
        words_in     = 0;
        results_out  = 0;
        bytes_latched = 0;
        endings      = '{0, 0, 0, 0};
        cfg_term     = gpib_ah_pkg::TerminatorReset;
        cfg_max      = gpib_ah_pkg::MaxCountReset;
        cfg_timeout  = gpib_ah_pkg::TimeoutReset;
        lp_phase     = gpib_ah_pkg::PH_IDLE;
        lp_timer     = '0;
        lp_count     = '0;
        lp_status    = gpib_ah_pkg::ST_OK;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_eoi_transfer();
        test_terminator_and_full();
        test_timeouts_and_restart();
        test_count_limits();
        test_random_traffic();

        settle();
        repeat (TailCycles) @(negedge aclk);
        $display("Run covered %0d words in, %0d results out, %0d bytes latched.",
                 words_in, results_out, bytes_latched);
        $display("Transfers ended: %0d ok, %0d DAV timeout, %0d full, %0d release timeout.",
                 endings[0], endings[1], endings[2], endings[3]);
        if (fault_count == 0 && due_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gpib_ah_pkg.sv
rtl/gpib_acceptor_handshake_core.sv
test/tb_gpib_acceptor_handshake_core.sv
